@@ rtl/ptfg_pkg.sv @@
// Shared types and constants of the polyline tube frame generator.
package ptfg_pkg;

   localparam int ONE_Q14 = 16384;
   localparam int DIV_STEPS = 16;
   localparam int SQRT_STEPS = 32;
   localparam int U_LIMIT_LOG2 = 20;
   localparam int V_TARGET_LOG2 = 29;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_COMMIT,
      OP_TAN,
      OP_TT,
      OP_HALVE,
      OP_DOT,
      OP_MDU,
      OP_DIV,
      OP_SETV,
      OP_VSHIFT,
      OP_VV,
      OP_SQI,
      OP_SQ,
      OP_NDI,
      OP_SETN,
      OP_LOAD,
      OP_SHOW
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] comp;
      logic [4:0] step;
      logic       take;
      logic       second;
      logic       one_sided;
      logic       seed;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic       clear;
      logic       eol;
      logic [1:0] seen;
      logic       tt_pass;
      logic       u_big;
      logic       v_zero;
      logic       v_small;
      logic       out_busy;
   } stat_type;

endpackage

@@ rtl/ptfg_datapath.sv @@
// Datapath of the tube frame generator: point history, tangent, normal arithmetic, output.
module ptfg_datapath import ptfg_pkg::*; #(
   parameter int MAX_VERTICES = 65536,
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    st,
   input  logic        req_valid,
   input  logic        req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [47:0] req_color_rgb,
   input  logic        req_end_of_line,
   input  logic        csr_valid,
   input  logic [62:0] csr_min_tangent_sq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vert_x,
   output logic [31:0] rsp_vert_y,
   output logic [31:0] rsp_vert_z,
   output logic [31:0] rsp_tan_x,
   output logic [31:0] rsp_tan_y,
   output logic [31:0] rsp_tan_z,
   output logic [15:0] rsp_norm_x,
   output logic [15:0] rsp_norm_y,
   output logic [15:0] rsp_norm_z,
   output logic [47:0] rsp_vert_color,
   output logic [15:0] rsp_vert_index,
   output logic        rsp_last_of_line
);

   localparam int CWB = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int SH = 32 - CWB;
   localparam int IDXW = $clog2(MAX_VERTICES);
   localparam logic signed [33:0] SAT_HI = 34'((64'sd1 <<< (CWB - 1)) - 64'sd1);
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;
   localparam logic signed [31:0] U_LIM = 32'sd1 <<< U_LIMIT_LOG2;
   localparam logic signed [31:0] V_LIM = 32'sd1 <<< V_TARGET_LOG2;

   logic signed [31:0] p_ff [3];
   logic signed [31:0] before_ff [3];
   logic signed [31:0] held_ff [3];
   logic signed [31:0] t_ff [3];
   logic signed [31:0] u_ff [3];
   logic signed [31:0] v_ff [3];
   logic signed [15:0] car_ff [3];
   logic signed [15:0] nres_ff [3];
   logic [47:0] col_ff, hcol_ff;
   logic eol_ff, clr_ff;
   logic [1:0] seen_ff;
   logic [IDXW-1:0] cnt_ff;
   logic [62:0] min_ff;
   logic [63:0] tt_ff;
   logic signed [37:0] d_ff;
   logic [41:0] uu_ff;
   logic [57:0] rem_ff;
   logic [41:0] dvs_ff;
   logic [15:0] q_ff;
   logic neg_ff;
   logic [63:0] vv_ff, x_ff, r_ff;
   logic signed [31:0] opos_ff [3];
   logic signed [31:0] otan_ff [3];
   logic signed [15:0] on_ff [3];
   logic [47:0] ocol_ff;
   logic [IDXW-1:0] oidx_ff;
   logic olast_ff, ovalid_ff;

   logic signed [31:0] p_in [3];
   logic signed [31:0] t_new [3];
   logic signed [31:0] u_half [3];
   logic [31:0] req_pos [3];
   logic signed [33:0] diff, half, sat;
   logic [32:0] abs_t1, abs_t2;
   logic signed [31:0] tc, uc, vc;
   logic signed [20:0] u21;
   logic signed [15:0] pc;
   logic signed [63:0] tsq, vsq;
   logic signed [36:0] pu;
   logic signed [41:0] uusq;
   logic signed [58:0] du;
   logic [57:0] du_mag, shifted, nd_mag;
   logic [63:0] sq_bit, sq_sum;
   logic signed [16:0] qs;
   logic [IDXW+15:0] idx_ext;
   logic v_zero, v_small, u_big;

   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = $signed(req_pos[i] << SH) >>> SH;
      end
   end

   always_comb begin
      diff = '0;
      half = '0;
      sat = '0;
      for (int i = 0; i < 3; i++) begin
         diff = cmd.one_sided ? (34'(p_ff[i]) - 34'(held_ff[i]))
                              : (34'(p_ff[i]) - 34'(before_ff[i]));
         half = cmd.one_sided ? diff : ((diff + $signed({33'd0, diff[33]})) >>> 1);
         sat = (half > SAT_HI) ? SAT_HI : ((half < SAT_LO) ? SAT_LO : half);
         t_new[i] = 32'(sat);
         u_half[i] = (u_ff[i] + $signed({31'd0, u_ff[i][31]})) >>> 1;
      end
   end

   assign abs_t1 = t_new[1][31] ? 33'(-34'(t_new[1])) : 33'(t_new[1]);
   assign abs_t2 = t_new[2][31] ? 33'(-34'(t_new[2])) : 33'(t_new[2]);

   assign tc = t_ff[cmd.comp];
   assign uc = u_ff[cmd.comp];
   assign vc = v_ff[cmd.comp];
   assign pc = car_ff[cmd.comp];
   assign u21 = uc[20:0];
   assign tsq = tc * tc;
   assign vsq = vc * vc;
   assign pu = 37'(pc) * 37'(u21);
   assign uusq = 42'(u21) * 42'(u21);
   assign du = 59'(d_ff) * 59'(u21);
   assign du_mag = du[58] ? 58'(-du) : 58'(du);
   assign nd_mag = 58'(vc[31] ? 33'(-33'(vc)) : 33'(vc)) << 14;
   assign shifted = 58'(dvs_ff) << cmd.step[3:0];
   assign sq_bit = 64'd1 << {cmd.step, 1'b0};
   assign sq_sum = r_ff + sq_bit;
   assign qs = neg_ff ? -17'(q_ff) : 17'(q_ff);
   assign idx_ext = {16'b0, oidx_ff};

   always_comb begin
      v_zero = 1'b1;
      v_small = 1'b1;
      u_big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (v_ff[i] != 0) v_zero = 1'b0;
         if (v_ff[i] >= V_LIM || v_ff[i] <= -V_LIM) v_small = 1'b0;
         if (u_ff[i] >= U_LIM || u_ff[i] <= -U_LIM) u_big = 1'b1;
      end
   end

   assign st.clear = clr_ff;
   assign st.eol = eol_ff;
   assign st.seen = seen_ff;
   assign st.tt_pass = (tt_ff != 64'd0) && (tt_ff >= {1'b0, min_ff});
   assign st.u_big = u_big;
   assign st.v_zero = v_zero;
   assign st.v_small = v_small;
   assign st.out_busy = ovalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 63'd512;
      end else if (csr_valid) begin
         min_ff <= csr_min_tangent_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         cnt_ff <= '0;
         hcol_ff <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            before_ff[i] <= '0;
            held_ff[i] <= '0;
            car_ff[i] <= '0;
         end
      end else begin
         if (ovalid_ff && rsp_ready) ovalid_ff <= 1'b0;
         if (cmd.take && req_valid) begin
            clr_ff <= req_opcode;
            eol_ff <= req_end_of_line;
            col_ff <= req_color_rgb;
            for (int i = 0; i < 3; i++) p_ff[i] <= p_in[i];
         end
         case (cmd.op)
            OP_CLEAR: begin
               seen_ff <= '0;
               cnt_ff <= '0;
               hcol_ff <= '0;
               for (int i = 0; i < 3; i++) begin
                  before_ff[i] <= '0;
                  held_ff[i] <= '0;
                  car_ff[i] <= '0;
               end
            end
            OP_COMMIT: begin
               if (seen_ff == 2'd0) begin
                  if (!eol_ff) begin
                     for (int i = 0; i < 3; i++) held_ff[i] <= p_ff[i];
                     hcol_ff <= col_ff;
                     seen_ff <= 2'd1;
                  end
               end else if (eol_ff) begin
                  seen_ff <= 2'd0;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     before_ff[i] <= held_ff[i];
                     held_ff[i] <= p_ff[i];
                  end
                  hcol_ff <= col_ff;
                  seen_ff <= 2'd2;
               end
            end
            OP_TAN: begin
               for (int i = 0; i < 3; i++) t_ff[i] <= t_new[i];
               if (cmd.seed) begin
                  car_ff[0] <= (abs_t1 > abs_t2) ? 16'sd0 : 16'(ONE_Q14);
                  car_ff[1] <= 16'sd0;
                  car_ff[2] <= (abs_t1 > abs_t2) ? 16'(ONE_Q14) : 16'sd0;
               end
            end
            OP_TT: begin
               tt_ff <= ((cmd.step == 5'd0) ? 64'd0 : tt_ff) + 64'(tsq);
               if (cmd.step == 5'd0) begin
                  for (int i = 0; i < 3; i++) u_ff[i] <= t_ff[i];
               end
            end
            OP_HALVE: begin
               for (int i = 0; i < 3; i++) u_ff[i] <= u_half[i];
            end
            OP_DOT: begin
               d_ff <= ((cmd.step == 5'd0) ? 38'sd0 : d_ff) + 38'(pu);
               uu_ff <= ((cmd.step == 5'd0) ? 42'd0 : uu_ff) + 42'(uusq);
            end
            OP_MDU: begin
               rem_ff <= (uu_ff == 42'd0) ? 58'd0 : du_mag;
               dvs_ff <= uu_ff;
               neg_ff <= du[58];
               q_ff <= '0;
            end
            OP_DIV: begin
               if (rem_ff >= shifted) begin
                  rem_ff <= rem_ff - shifted;
                  q_ff[cmd.step[3:0]] <= 1'b1;
               end
            end
            OP_SETV: begin
               v_ff[cmd.comp] <= 32'(pc) - 32'(qs);
            end
            OP_VSHIFT: begin
               for (int i = 0; i < 3; i++) v_ff[i] <= v_ff[i] <<< 1;
            end
            OP_VV: begin
               vv_ff <= ((cmd.step == 5'd0) ? 64'd0 : vv_ff) + 64'(vsq);
            end
            OP_SQI: begin
               x_ff <= vv_ff;
               r_ff <= '0;
            end
            OP_SQ: begin
               if (x_ff >= sq_sum) begin
                  x_ff <= x_ff - sq_sum;
                  r_ff <= (r_ff >> 1) + sq_bit;
               end else begin
                  r_ff <= r_ff >> 1;
               end
            end
            OP_NDI: begin
               rem_ff <= nd_mag;
               dvs_ff <= 42'(r_ff);
               neg_ff <= vc[31];
               q_ff <= '0;
            end
            OP_SETN: begin
               nres_ff[cmd.comp] <= 16'(qs);
            end
            OP_LOAD: begin
               for (int i = 0; i < 3; i++) begin
                  opos_ff[i] <= cmd.second ? p_ff[i] : held_ff[i];
                  otan_ff[i] <= t_ff[i];
                  on_ff[i] <= v_zero ? car_ff[i] : nres_ff[i];
                  car_ff[i] <= v_zero ? car_ff[i] : nres_ff[i];
               end
               ocol_ff <= cmd.second ? col_ff : hcol_ff;
               oidx_ff <= cnt_ff;
               cnt_ff <= (cnt_ff == IDXW'(MAX_VERTICES - 1)) ? '0 : cnt_ff + 1'b1;
            end
            OP_SHOW: begin
               ovalid_ff <= 1'b1;
               olast_ff <= cmd.last;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_vert_x = opos_ff[0];
   assign rsp_vert_y = opos_ff[1];
   assign rsp_vert_z = opos_ff[2];
   assign rsp_tan_x = otan_ff[0];
   assign rsp_tan_y = otan_ff[1];
   assign rsp_tan_z = otan_ff[2];
   assign rsp_norm_x = on_ff[0];
   assign rsp_norm_y = on_ff[1];
   assign rsp_norm_z = on_ff[2];
   assign rsp_vert_color = ocol_ff;
   assign rsp_vert_index = idx_ext[15:0];
   assign rsp_last_of_line = olast_ff;

endmodule

@@ rtl/ptfg_controller.sv @@
// Sequencing state machine of the tube frame generator.
module ptfg_controller import ptfg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [20:0] {
      S_IDLE   = 21'd1 << 0,
      S_DECODE = 21'd1 << 1,
      S_TAN    = 21'd1 << 2,
      S_TT     = 21'd1 << 3,
      S_CHK    = 21'd1 << 4,
      S_SCALE  = 21'd1 << 5,
      S_DOT    = 21'd1 << 6,
      S_MDU    = 21'd1 << 7,
      S_DIV    = 21'd1 << 8,
      S_SETV   = 21'd1 << 9,
      S_VCHK   = 21'd1 << 10,
      S_VSH    = 21'd1 << 11,
      S_VV     = 21'd1 << 12,
      S_SQI    = 21'd1 << 13,
      S_SQ     = 21'd1 << 14,
      S_NDI    = 21'd1 << 15,
      S_SETN   = 21'd1 << 16,
      S_LOAD   = 21'd1 << 17,
      S_SHOW   = 21'd1 << 18,
      S_WAIT   = 21'd1 << 19,
      S_COMMIT = 21'd1 << 20
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] k_ff, k_in;
   logic [1:0] c_ff, c_in;
   logic second_ff, second_in, pend_ff, pend_in, divn_ff, divn_in;
   logic goon_ff, goon_in, last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff <= '0;
         c_ff <= '0;
         second_ff <= 1'b0;
         pend_ff <= 1'b0;
         divn_ff <= 1'b0;
         goon_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         c_ff <= c_in;
         second_ff <= second_in;
         pend_ff <= pend_in;
         divn_ff <= divn_in;
         goon_ff <= goon_in;
         last_ff <= last_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      c_in = c_ff;
      second_in = second_ff;
      pend_in = pend_ff;
      divn_in = divn_ff;
      goon_in = goon_ff;
      last_in = last_ff;
      cmd.op = OP_NONE;
      cmd.comp = c_ff;
      cmd.step = k_ff;
      cmd.take = 1'b0;
      cmd.second = second_ff;
      cmd.one_sided = second_ff || (st.seen == 2'd1);
      cmd.seed = !second_ff && (st.seen == 2'd1);
      cmd.last = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            second_in = 1'b0;
            pend_in = 1'b0;
            if (st.clear) begin
               cmd.op = OP_CLEAR;
               state_in = S_IDLE;
            end else if (st.seen == 2'd0) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_TAN;
            end
         end
         S_TAN: begin
            cmd.op = OP_TAN;
            k_in = '0;
            state_in = S_TT;
         end
         S_TT: begin
            cmd.op = OP_TT;
            cmd.comp = k_ff[1:0];
            if (k_ff == 5'd2) state_in = S_CHK;
            else k_in = k_ff + 5'd1;
         end
         S_CHK: begin
            if (second_ff && pend_ff) begin
               last_in = !st.tt_pass;
               goon_in = st.tt_pass;
               state_in = S_SHOW;
            end else if (st.tt_pass) begin
               state_in = S_SCALE;
            end else if (!second_ff && st.eol) begin
               second_in = 1'b1;
               pend_in = 1'b0;
               state_in = S_TAN;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SCALE: begin
            if (st.u_big) begin
               cmd.op = OP_HALVE;
            end else begin
               k_in = '0;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            cmd.op = OP_DOT;
            cmd.comp = k_ff[1:0];
            if (k_ff == 5'd2) begin
               c_in = '0;
               state_in = S_MDU;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         S_MDU: begin
            cmd.op = OP_MDU;
            divn_in = 1'b0;
            k_in = 5'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (k_ff == 5'd0) state_in = divn_ff ? S_SETN : S_SETV;
            else k_in = k_ff - 5'd1;
         end
         S_SETV: begin
            cmd.op = OP_SETV;
            if (c_ff == 2'd2) begin
               state_in = S_VCHK;
            end else begin
               c_in = c_ff + 2'd1;
               state_in = S_MDU;
            end
         end
         S_VCHK: begin
            state_in = st.v_zero ? S_LOAD : S_VSH;
         end
         S_VSH: begin
            if (st.v_small) begin
               cmd.op = OP_VSHIFT;
            end else begin
               k_in = '0;
               state_in = S_VV;
            end
         end
         S_VV: begin
            cmd.op = OP_VV;
            cmd.comp = k_ff[1:0];
            if (k_ff == 5'd2) state_in = S_SQI;
            else k_in = k_ff + 5'd1;
         end
         S_SQI: begin
            cmd.op = OP_SQI;
            k_in = 5'(SQRT_STEPS - 1);
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            if (k_ff == 5'd0) begin
               c_in = '0;
               state_in = S_NDI;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         S_NDI: begin
            cmd.op = OP_NDI;
            divn_in = 1'b1;
            k_in = 5'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         S_SETN: begin
            cmd.op = OP_SETN;
            if (c_ff == 2'd2) begin
               state_in = S_LOAD;
            end else begin
               c_in = c_ff + 2'd1;
               state_in = S_NDI;
            end
         end
         S_LOAD: begin
            cmd.op = OP_LOAD;
            if (second_ff) begin
               last_in = 1'b1;
               goon_in = 1'b0;
               state_in = S_SHOW;
            end else if (st.eol) begin
               second_in = 1'b1;
               pend_in = 1'b1;
               state_in = S_TAN;
            end else begin
               last_in = 1'b0;
               goon_in = 1'b0;
               state_in = S_SHOW;
            end
         end
         S_SHOW: begin
            cmd.op = OP_SHOW;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (!st.out_busy) begin
               pend_in = 1'b0;
               state_in = goon_ff ? S_SCALE : S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.op = OP_COMMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/polyline_tube_frame_generator.sv @@
// Top level of the polyline tube frame generator.
// Polyline points enter on the req_ channel, one beat per point; tube vertices
// leave on the rsp_ channel, one beat per vertex. A vertex is held back by one
// point, so a point ending a line can give two vertices and a first point none.
// The csr_ channel writes the skip threshold min_tangent_sq and is always ready;
// write it only while the block is idle.
// One point is handled at a time. A point that emits a vertex halves the tangent
// up to 12 times, runs three 16-step divisions and, unless the projected normal
// is zero, doubles it up to 29 times and runs a 32-step square root and three
// more 16-step divisions; all six share one restoring divider. A point ending a
// line with two vertices does this work for each of them.
// The input is taken again only after every vertex of the previous beat has
// been delivered. When the receiver stalls, the finished vertex waits in the
// output register and the computation halts until it is taken.
// Synchronous reset clears the point history, normal and vertex counter, and
// sets the threshold to 512. A clear beat does the same but keeps the threshold.
module polyline_tube_frame_generator import ptfg_pkg::*; #(
   parameter int MAX_VERTICES = 65536,
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [47:0] req_color_rgb,
   input  logic        req_end_of_line,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [62:0] csr_min_tangent_sq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vert_x,
   output logic [31:0] rsp_vert_y,
   output logic [31:0] rsp_vert_z,
   output logic [31:0] rsp_tan_x,
   output logic [31:0] rsp_tan_y,
   output logic [31:0] rsp_tan_z,
   output logic [15:0] rsp_norm_x,
   output logic [15:0] rsp_norm_y,
   output logic [15:0] rsp_norm_z,
   output logic [47:0] rsp_vert_color,
   output logic [15:0] rsp_vert_index,
   output logic        rsp_last_of_line
);

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   ptfg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ptfg_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_valid          (req_valid),
      .req_opcode         (req_opcode),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_color_rgb      (req_color_rgb),
      .req_end_of_line    (req_end_of_line),
      .csr_valid          (csr_valid),
      .csr_min_tangent_sq (csr_min_tangent_sq),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_vert_x         (rsp_vert_x),
      .rsp_vert_y         (rsp_vert_y),
      .rsp_vert_z         (rsp_vert_z),
      .rsp_tan_x          (rsp_tan_x),
      .rsp_tan_y          (rsp_tan_y),
      .rsp_tan_z          (rsp_tan_z),
      .rsp_norm_x         (rsp_norm_x),
      .rsp_norm_y         (rsp_norm_y),
      .rsp_norm_z         (rsp_norm_z),
      .rsp_vert_color     (rsp_vert_color),
      .rsp_vert_index     (rsp_vert_index),
      .rsp_last_of_line   (rsp_last_of_line)
   );

endmodule

@@ bench/ptfg_frame_checker.sv @@
// Checker of the tube frame generator: predicts vertices and compares rsp_ beats.
`timescale 1ns / 100ps
module ptfg_frame_checker import ptfg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [47:0] req_color_rgb,
   input  logic        req_end_of_line,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [62:0] csr_min_tangent_sq,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_vert_x,
   input  logic [31:0] rsp_vert_y,
   input  logic [31:0] rsp_vert_z,
   input  logic [31:0] rsp_tan_x,
   input  logic [31:0] rsp_tan_y,
   input  logic [31:0] rsp_tan_z,
   input  logic [15:0] rsp_norm_x,
   input  logic [15:0] rsp_norm_y,
   input  logic [15:0] rsp_norm_z,
   input  logic [47:0] rsp_vert_color,
   input  logic [15:0] rsp_vert_index,
   input  logic        rsp_last_of_line,
   output int          errors,
   output int          pending
);

   typedef longint vec3_type [3];

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] tng [3];
      logic [15:0] nrm [3];
      logic [47:0] color;
      logic [15:0] index;
      logic        last;
   } vertex_type;

   vertex_type vertex_q [$];

   logic [62:0] skip_threshold;
   vec3_type    prior_pt;
   vec3_type    held_pt;
   logic [47:0] held_col;
   vec3_type    frame_normal;
   int          seen_count;
   logic [15:0] vertex_number;

   assign pending = vertex_q.size();

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic transport_normal(input vec3_type t, output vec3_type n);
      vec3_type u;
      vec3_type v;
      longint mx, d, uu, dv, m, f;
      longint unsigned vv, len;
      mx = 0; d = 0; uu = 0; dv = 1; m = 0; f = 1; vv = 0;
      for (int i = 0; i < 3; i++) if (abs64(t[i]) > mx) mx = abs64(t[i]);
      while (mx / dv >= (64'sd1 << 20)) dv = dv * 2;
      for (int i = 0; i < 3; i++) begin
         u[i] = t[i] / dv;
         d = d + frame_normal[i] * u[i];
         uu = uu + u[i] * u[i];
      end
      for (int i = 0; i < 3; i++) begin
         v[i] = frame_normal[i] - (uu != 0 ? d * u[i] / uu : 64'sd0);
         if (abs64(v[i]) > m) m = abs64(v[i]);
      end
      if (m == 0) begin
         n = frame_normal;
         return;
      end
      while (m * f < (64'sd1 << 29)) f = f * 2;
      for (int i = 0; i < 3; i++) begin
         v[i] = v[i] * f;
         vv = vv + longint'(v[i] * v[i]);
      end
      len = root64(vv);
      for (int i = 0; i < 3; i++) n[i] = v[i] * 16384 / longint'(len);
   endtask

   task automatic make_vertex(input vec3_type p, input vec3_type t, input logic [47:0] col,
                              inout vertex_type outv [2], inout int cnt);
      longint unsigned tt;
      vec3_type n;
      tt = 0;
      for (int i = 0; i < 3; i++) tt = tt + longint'(t[i] * t[i]);
      if (tt == 0 || tt < {1'b0, skip_threshold}) return;
      transport_normal(t, n);
      for (int i = 0; i < 3; i++) begin
         outv[cnt].pos[i] = p[i][31:0];
         outv[cnt].tng[i] = t[i][31:0];
         outv[cnt].nrm[i] = n[i][15:0];
         frame_normal[i] = n[i];
      end
      outv[cnt].color = col;
      outv[cnt].index = vertex_number;
      outv[cnt].last = 1'b0;
      vertex_number = vertex_number + 16'd1;
      cnt++;
   endtask

   task automatic clear_history();
      for (int i = 0; i < 3; i++) begin
         prior_pt[i] = 0;
         held_pt[i] = 0;
         frame_normal[i] = 0;
      end
      held_col = '0;
      seen_count = 0;
      vertex_number = '0;
   endtask

   task automatic predict_point();
      vec3_type p;
      vec3_type t;
      vertex_type outv [2];
      int cnt;
      cnt = 0;
      if (req_opcode) begin
         clear_history();
         return;
      end
      p[0] = longint'(signed'(req_pos_x));
      p[1] = longint'(signed'(req_pos_y));
      p[2] = longint'(signed'(req_pos_z));
      if (seen_count == 0) begin
         if (!req_end_of_line) begin
            held_pt = p;
            held_col = req_color_rgb;
            seen_count = 1;
         end
         return;
      end
      if (seen_count == 1) begin
         for (int i = 0; i < 3; i++) t[i] = sat32(p[i] - held_pt[i]);
         frame_normal[0] = abs64(t[1]) > abs64(t[2]) ? 0 : 16384;
         frame_normal[1] = 0;
         frame_normal[2] = abs64(t[1]) > abs64(t[2]) ? 16384 : 0;
      end else begin
         for (int i = 0; i < 3; i++) t[i] = sat32((p[i] - prior_pt[i]) / 2);
      end
      make_vertex(held_pt, t, held_col, outv, cnt);
      if (req_end_of_line) begin
         for (int i = 0; i < 3; i++) t[i] = sat32(p[i] - held_pt[i]);
         make_vertex(p, t, req_color_rgb, outv, cnt);
         if (cnt > 0) outv[cnt - 1].last = 1'b1;
         seen_count = 0;
      end else begin
         prior_pt = held_pt;
         held_pt = p;
         held_col = req_color_rgb;
         seen_count = 2;
      end
      for (int i = 0; i < cnt; i++) vertex_q = {vertex_q, outv[i]};
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_vertex();
      vertex_type w;
      if (vertex_q.size() == 0) begin
         $display("%0t: vertex beat with none expected, actual index %h", $time,
                  rsp_vert_index);
         errors++;
         return;
      end
      w = vertex_q.pop_front();
      compare_field("vert_x", w.pos[0], rsp_vert_x);
      compare_field("vert_y", w.pos[1], rsp_vert_y);
      compare_field("vert_z", w.pos[2], rsp_vert_z);
      compare_field("tan_x", w.tng[0], rsp_tan_x);
      compare_field("tan_y", w.tng[1], rsp_tan_y);
      compare_field("tan_z", w.tng[2], rsp_tan_z);
      compare_field("norm_x", w.nrm[0], rsp_norm_x);
      compare_field("norm_y", w.nrm[1], rsp_norm_y);
      compare_field("norm_z", w.nrm[2], rsp_norm_z);
      compare_field("vert_color", w.color, rsp_vert_color);
      compare_field("vert_index", w.index, rsp_vert_index);
      compare_field("last_of_line", w.last, rsp_last_of_line);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         skip_threshold <= 63'd512;
         vertex_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_vertex();
         if (req_valid && req_ready) predict_point();
         if (csr_valid && csr_ready) skip_threshold <= csr_min_tangent_sq;
      end
   end

endmodule

@@ bench/tb.sv @@
// Testbench top of the polyline tube frame generator: stimulus and verdict.
`timescale 1ns / 100ps
module tb;

   localparam int STALL_LIMIT = 10000;
   localparam int SETTLE_CYCLES = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic [47:0] req_color_rgb = '0;
   logic        req_end_of_line = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [62:0] csr_min_tangent_sq = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_vert_x, rsp_vert_y, rsp_vert_z;
   logic [31:0] rsp_tan_x, rsp_tan_y, rsp_tan_z;
   logic [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [47:0] rsp_vert_color;
   logic [15:0] rsp_vert_index;
   logic        rsp_last_of_line;

   int errors;
   int pending;
   int idle_cycles = 0;
   int point_count = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   always #6 clock = ~clock;

   polyline_tube_frame_generator dut (.*);

   ptfg_frame_checker frame_check (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         repeat ($urandom_range(200, 2000)) @(posedge clock);
         calm = ~calm;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (800) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = draw_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_beat(input bit op, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [47:0] col, input bit eol);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_color_rgb <= col;
      req_end_of_line <= eol;
      do @(posedge clock); while (!req_ready);
      point_count++;
   endtask

   task automatic set_threshold(input logic [62:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_min_tangent_sq <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [47:0] any_color();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [31:0] any_step();
      logic [31:0] s;
      s = $urandom;
      return $signed(s) >>> $urandom_range(4, 30);
   endfunction

   task automatic random_line();
      logic [31:0] x, y, z;
      int len;
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom; y = $urandom; z = $urandom;
      end else begin
         x = any_step(); y = any_step(); z = any_step();
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            send_beat(1'b1, $urandom, $urandom, $urandom, any_color(), 1'($urandom));
            return;
         end
         send_beat(1'b0, x, y, z, any_color(), i == len - 1);
         case ($urandom_range(0, 9))
            0: ;
            1: begin
               x = $urandom; y = $urandom; z = $urandom;
            end
            2: x = x + any_step();
            default: begin
               x = x + any_step(); y = y + any_step(); z = z + any_step();
            end
         endcase
      end
   endtask

   task automatic random_phase(input int count, input bit squeeze);
      int goal;
      goal = point_count + count;
      while (point_count < goal) begin
         if (squeeze && point_count >= goal - count / 2) begin
            hold_request = 1'b1;
            squeeze = 1'b0;
         end
         random_line();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_threshold(63'd512);

      send_beat(1'b1, '0, '0, '0, '0, 1'b0);
      send_beat(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_beat(1'b0, 32'h0, 32'h0, 32'h0, 48'h0, 1'b0);
      send_beat(1'b0, 32'h0001_0000, 32'h0, 32'h0, 48'h1234_5678_9ABC, 1'b1);
      send_beat(1'b0, 32'h0, 32'h0, 32'h0, 48'h1, 1'b0);
      send_beat(1'b0, 32'h0, 32'h0005_0000, 32'h0, 48'h2, 1'b0);
      send_beat(1'b0, 32'h0003_0000, 32'h0007_0000, 32'h0001_0000, 48'h3, 1'b1);
      send_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_beat(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h0, 1'b0);
      send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b1);
      send_beat(1'b0, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 48'h5, 1'b0);
      send_beat(1'b0, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 48'h6, 1'b0);
      send_beat(1'b0, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 48'h7, 1'b1);
      send_beat(1'b0, 32'h0, 32'h0, 32'h0, 48'h8, 1'b0);
      send_beat(1'b0, 32'h0002_0000, 32'h0, 32'h0001_0000, 48'h9, 1'b0);
      send_beat(1'b0, 32'h0002_0000, 32'h0, 32'h0001_0000, 48'hA, 1'b1);
      send_beat(1'b0, 32'h0001_0000, 32'h0, 32'h0, 48'hB, 1'b0);
      send_beat(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0, 48'hC, 1'b0);
      send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_beat(1'b0, 32'hFFFF_0000, 32'h0, 32'h0, 48'hD, 1'b0);
      send_beat(1'b0, 32'h0, 32'h0, 32'hFFFF_0000, 48'hE, 1'b1);
      random_phase(140, 1'b0);

      set_threshold(63'd0);
      send_beat(1'b0, 32'h10, 32'h20, 32'h30, 48'h1, 1'b0);
      send_beat(1'b0, 32'h10, 32'h20, 32'h30, 48'h2, 1'b0);
      send_beat(1'b0, 32'h11, 32'h20, 32'h30, 48'h3, 1'b1);
      random_phase(150, 1'b1);

      set_threshold(63'd1 << 40);
      random_phase(120, 1'b0);

      set_threshold(63'h7FFF_FFFF_FFFF_FFFF);
      random_phase(20, 1'b0);

      set_threshold({31'($urandom), 32'($urandom)} >> $urandom_range(20, 62));
      random_phase(100, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
